[rtl/core/irmc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package irmc_pkg;

   localparam int DEF_MAX_STATIONS = 1024;

   localparam int FUNC_W    = 2;
   localparam int STATION_W = 10;
   localparam int FARE_W    = 20;
   localparam int COST_W    = 31;
   localparam int COUNT_W   = 11;

   localparam int REQ_DATA_W = ((2 * STATION_W + FARE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((COST_W + 7) / 8) * 8;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RELAX = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

   localparam logic [COST_W-1:0] COST_INF = 31'h7FFF_FFFF;
   localparam logic [COST_W-1:0] COST_MAX = 31'h7FFF_FFFE;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_UPD_L,
      ST_UPD_R,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [STATION_W-1:0] start_station;
      logic [STATION_W-1:0] end_station;
      logic [FARE_W-1:0]    fare;
   } item_type;

   typedef struct packed {
      logic              reachable;
      logic [COST_W-1:0] cost;
   } result_type;

   typedef struct packed {
      logic idle;
      logic done;
   } walk_status_type;

endpackage

`default_nettype wire

[rtl/core/interval_relax_min_cost_core.sv]
// Per-station minimum cost keeper. Costs live in a segment tree of 2*MAX_STATIONS tags held in
// one memory; a station's cost is the minimum of the tags on its leaf-to-root path. Each
// transaction is worked by a small sequencer over the single memory port pair, one tag per
// cycle. A query makes one leaf-to-root walk; a relax then does the saturating add in ST_CALC
// and the range walk, with read-modify-write of each tag, through ST_UPD_L and ST_UPD_R for
// each tree level until ST_UPD_L closes the walk. A clear rewrites every tag. After reset the
// same clearing pass runs with req_tready low; csr writes are taken at any time. Every request
// returns exactly one response; reachable is 0 (cost 0) for clears, unused codes and stations
// at or above station_count (a count of 0 acts as 1, one above MAX_STATIONS as MAX_STATIONS).
`timescale 1ns / 1ps
`default_nettype none

module interval_relax_min_cost_core #(
   parameter int MAX_STATIONS = irmc_pkg::DEF_MAX_STATIONS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // start_station, end_station, fare
   input  wire logic [irmc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func
   input  wire logic [irmc_pkg::FUNC_W-1:0]       req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // cost
   output logic [irmc_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // reachable
   output logic                                   rsp_tuser,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [irmc_pkg::COUNT_W-1:0]      csr_data
);
   import irmc_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   item_type           item;
   walk_status_type    status;
   result_type         result;
   logic               start, rsp_free;

   assign item.func          = req_tuser;
   assign item.start_station = req_tdata[STATION_W-1:0];
   assign item.end_station   = req_tdata[2*STATION_W-1:STATION_W];
   assign item.fare          = req_tdata[2*STATION_W+FARE_W-1:2*STATION_W];

   assign req_tready = status.idle;
   assign start      = req_tvalid && status.idle;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   irmc_walk #(
      .MAX_STATIONS (MAX_STATIONS)
   ) u_walk (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .item          (item),
      .station_count (count_ff),
      .rsp_free      (rsp_free),
      .status        (status),
      .result        (result)
   );

   always_comb begin
      count_in     = csr_valid ? csr_data : count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (status.done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_ff.cost);
   assign rsp_tuser  = rsp_ff.reachable;

endmodule

`default_nettype wire

[rtl/core/irmc_walk.sv]
`timescale 1ns / 1ps
`default_nettype none

module irmc_walk #(
   parameter int MAX_STATIONS = irmc_pkg::DEF_MAX_STATIONS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire irmc_pkg::item_type             item,
   input  wire logic [irmc_pkg::COUNT_W-1:0]   station_count,
   input  wire logic                           rsp_free,
   output irmc_pkg::walk_status_type           status,
   output irmc_pkg::result_type                result
);
   import irmc_pkg::*;

   localparam int AW  = $clog2(2 * MAX_STATIONS);
   localparam int IW  = AW + 1;
   localparam int CW0 = $clog2(MAX_STATIONS + 1);
   localparam int CW  = (CW0 > COUNT_W) ? CW0 : COUNT_W;
   localparam int XW  = (IW > CW) ? IW : CW;

   localparam logic [AW-1:0] LAST_ADDR  = AW'(2 * MAX_STATIONS - 1);
   localparam logic [AW-1:0] START_LEAF = AW'(MAX_STATIONS);
   localparam logic [XW-1:0] MAX_X      = XW'(MAX_STATIONS);

   logic [COST_W-1:0] mem [0:2*MAX_STATIONS-1];
   logic [COST_W-1:0] rdata_ff;

   state_type         state_ff, state_in;
   item_type          item_ff, item_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [IW-1:0]     hi_ff, hi_in;
   logic [COST_W-1:0] best_ff, best_in;
   logic [COST_W-1:0] nv_ff, nv_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              wb_pend_ff, wb_pend_in;
   logic [AW-1:0]     wb_addr_ff, wb_addr_in;
   logic [AW-1:0]     sweep_ff, sweep_in;
   logic              clr_rsp_ff, clr_rsp_in;

   logic              rd_en, wr_en, walk_rd, upd_rd;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic [COST_W-1:0] wr_data;

   logic [XW-1:0]     count_x, n_x, e_x, e_clip, s_ff_x;
   logic              in_range, is_lookup;
   logic [IW-1:0]     leaf_in, hi_dec;
   logic [COST_W:0]   sum;
   logic [COST_W-1:0] nv;

   always_comb begin
      count_x = XW'(station_count);
      if (count_x == '0) begin
         n_x = XW'(1);
      end else if (count_x > MAX_X) begin
         n_x = MAX_X;
      end else begin
         n_x = count_x;
      end
      in_range  = XW'(item.start_station) < n_x;
      is_lookup = (item.func == FUNC_RELAX) || (item.func == FUNC_QUERY);
      leaf_in   = IW'(XW'(item.start_station) + MAX_X);
      s_ff_x    = XW'(item_ff.start_station);
      e_x       = XW'(item_ff.end_station);
      e_clip    = (e_x > n_x - XW'(1)) ? n_x - XW'(1) : e_x;
      sum       = {1'b0, best_ff} + (COST_W + 1)'(item_ff.fare);
      nv        = (sum > {1'b0, COST_MAX}) ? COST_MAX : sum[COST_W-1:0];
      hi_dec    = hi_ff - IW'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (sweep_ff == LAST_ADDR) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (item.func == FUNC_CLEAR) begin
                  state_in = ST_SWEEP;
               end else if (is_lookup && in_range) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            if (idx_ff == '0 && !rd_pend_ff) begin
               if (item_ff.func == FUNC_RELAX && best_ff != COST_INF) begin
                  state_in = ST_CALC;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_CALC: begin
            state_in = (s_ff_x <= e_clip) ? ST_UPD_L : ST_DONE;
         end
         ST_UPD_L: begin
            state_in = (idx_ff < hi_ff) ? ST_UPD_R : ST_DONE;
         end
         ST_UPD_R: begin
            state_in = ST_UPD_L;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // memory port control and status
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = idx_ff[AW-1:0];
      walk_rd = 1'b0;
      upd_rd  = 1'b0;
      wr_en   = 1'b0;
      wr_addr = sweep_ff;
      wr_data = COST_INF;
      case (state_ff)
         ST_SWEEP: begin
            wr_en   = 1'b1;
            wr_data = (sweep_ff == START_LEAF) ? '0 : COST_INF;
         end
         ST_READ: begin
            if (idx_ff != '0) begin
               rd_en   = 1'b1;
               walk_rd = 1'b1;
            end
         end
         ST_UPD_L: begin
            if (idx_ff < hi_ff && idx_ff[0]) begin
               rd_en  = 1'b1;
               upd_rd = 1'b1;
            end
         end
         ST_UPD_R: begin
            if (hi_ff[0]) begin
               rd_en   = 1'b1;
               upd_rd  = 1'b1;
               rd_addr = hi_dec[AW-1:0];
            end
         end
         default: begin
         end
      endcase
      if (wb_pend_ff && nv_ff < rdata_ff) begin
         wr_en   = 1'b1;
         wr_addr = wb_addr_ff;
         wr_data = nv_ff;
      end
      status.idle = (state_ff == ST_IDLE);
      status.done = (state_ff == ST_DONE) && rsp_free;
   end

   // datapath
   always_comb begin
      item_in    = item_ff;
      idx_in     = idx_ff;
      hi_in      = hi_ff;
      best_in    = best_ff;
      nv_in      = nv_ff;
      sweep_in   = sweep_ff;
      clr_rsp_in = clr_rsp_ff;
      rd_pend_in = walk_rd;
      wb_pend_in = upd_rd;
      wb_addr_in = rd_addr;
      case (state_ff)
         ST_SWEEP: begin
            sweep_in = sweep_ff + AW'(1);
         end
         ST_IDLE: begin
            if (start) begin
               item_in    = item;
               idx_in     = leaf_in;
               best_in    = COST_INF;
               sweep_in   = '0;
               clr_rsp_in = (item.func == FUNC_CLEAR);
            end
         end
         ST_READ: begin
            if (idx_ff != '0) begin
               idx_in = idx_ff >> 1;
            end
            if (rd_pend_ff && rdata_ff < best_ff) begin
               best_in = rdata_ff;
            end
         end
         ST_CALC: begin
            nv_in  = nv;
            idx_in = IW'(s_ff_x + MAX_X);
            hi_in  = IW'(e_clip + MAX_X + XW'(1));
         end
         ST_UPD_L: begin
            if (idx_ff < hi_ff && idx_ff[0]) begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_UPD_R: begin
            idx_in = idx_ff >> 1;
            hi_in  = hi_ff[0] ? (hi_dec >> 1) : (hi_ff >> 1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SWEEP;
         rd_pend_ff <= 1'b0;
         wb_pend_ff <= 1'b0;
         sweep_ff   <= '0;
         clr_rsp_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_pend_in;
         wb_pend_ff <= wb_pend_in;
         sweep_ff   <= sweep_in;
         clr_rsp_ff <= clr_rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      idx_ff     <= idx_in;
      hi_ff      <= hi_in;
      best_ff    <= best_in;
      nv_ff      <= nv_in;
      wb_addr_ff <= wb_addr_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign result.reachable = (best_ff != COST_INF);
   assign result.cost      = (best_ff != COST_INF) ? best_ff : '0;

endmodule

`default_nettype wire
